FILE: rtl/core/lfh_pkg.sv
// Package for the LPC/FWH host cycle engine: phase codes, request kinds, nibble codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lfh_pkg;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_HEAD      = 3'd1,
        PH_TAR_DRIVE = 3'd2,
        PH_TAR_FREE  = 3'd3,
        PH_SYNC      = 3'd4,
        PH_DATA      = 3'd5,
        PH_END       = 3'd6,
        PH_ABORT     = 3'd7
    } phase_t;

    localparam logic [2:0] KIND_TICK      = 3'd0;
    localparam logic [2:0] KIND_LPC_READ  = 3'd1;
    localparam logic [2:0] KIND_LPC_WRITE = 3'd2;
    localparam logic [2:0] KIND_FWH_READ  = 3'd3;
    localparam logic [2:0] KIND_FWH_WRITE = 3'd4;
    localparam logic [2:0] KIND_FWH_RUN   = 3'd5;

    localparam logic [1:0] REG_SYNC_LIMIT = 2'd0;
    localparam logic [1:0] REG_BURST_EN   = 2'd1;
    localparam logic [1:0] REG_IDSEL      = 2'd2;
    localparam logic [1:0] REG_TOP_NIB    = 2'd3;

    localparam logic [3:0] NIB_LPC_START = 4'b0000;
    localparam logic [3:0] NIB_LPC_RD    = 4'b0100;
    localparam logic [3:0] NIB_LPC_WR    = 4'b0110;
    localparam logic [3:0] NIB_FWH_RD    = 4'b1101;
    localparam logic [3:0] NIB_FWH_WR    = 4'b1110;
    localparam logic [3:0] NIB_ONES      = 4'b1111;

    // one result of a bus clock
    typedef struct packed {
        logic [3:0] lad_out;
        logic       lad_drive;
        logic       frame_active;
        logic       byte_valid;
        logic [7:0] read_byte;
        logic       request_done;
        logic       status;
        logic       busy_res;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/lfh_out_buf.sv
// Two-entry skid buffer for results of the LPC/FWH host engine.
// Depends on lfh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lfh_out_buf
    import lfh_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         room,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      out_data
);
    result_t    mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign pop       = (count_reg != 2'd0) && !out_stall;
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rptr_reg];
    // room only when a slot is free at this edge
    assign room      = (count_reg != 2'd2);

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2))
        else $error("result buffer overflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");
    a_empty_no_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> !out_valid)
        else $error("valid with empty buffer");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/lfh_engine.sv
// Bus-clock engine: per accepted item, computes one result and the next state.
// Depends on lfh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lfh_engine
    import lfh_pkg::*;
#(
    parameter int BURST_BYTES  = 128,
    parameter int ADDRESS_BITS = 24
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [2:0]  kind,
    input  wire logic [23:0] address,
    input  wire logic [7:0]  write_data,
    input  wire logic [24:0] run_length,
    input  wire logic [3:0]  lad_in,
    input  wire logic [7:0]  sync_limit,
    input  wire logic        burst_en,
    input  wire logic [3:0]  idsel,
    input  wire logic [3:0]  top_nib,
    output result_t          res
);
    localparam int BB_BITS = $clog2(BURST_BYTES);
    localparam int NC_W    = $clog2(2 * BURST_BYTES + 1);
    localparam logic [3:0] SIZE_CODE = 4'(BB_BITS);
    localparam logic [NC_W-1:0] BURST_NIBS = NC_W'(2 * BURST_BYTES);

    phase_t                  phase_reg, phase_next;
    logic [2:0]              rkind_reg, rkind_next;
    logic [NC_W-1:0]         ncnt_reg, ncnt_next;
    logic [7:0]              scnt_reg, scnt_next;
    logic [ADDRESS_BITS-1:0] addr_reg, addr_next;
    logic [24:0]             left_reg, left_next;
    logic [7:0]              shift_reg, shift_next;
    logic                    bfail_reg, bfail_next;
    logic                    cburst_reg, cburst_next;

    logic       is_lpc, is_wr, go, cycle_end, cnt_byte;
    logic [31:0] full_addr;
    logic [3:0]  head_nib;
    logic [NC_W-1:0] ncnt_inc;

    function automatic logic pick_burst(input logic [2:0] k, input logic en,
                                        input logic bf,
                                        input logic [ADDRESS_BITS-1:0] a,
                                        input logic [24:0] left);
        logic r;
        r = (k == KIND_FWH_RUN) && en && !bf && (a[BB_BITS-1:0] == '0)
            && (left >= 25'(BURST_BYTES));
        return r;
    endfunction

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            rkind_reg  <= KIND_TICK;
            ncnt_reg   <= '0;
            scnt_reg   <= '0;
            addr_reg   <= '0;
            left_reg   <= '0;
            shift_reg  <= '0;
            bfail_reg  <= 1'b0;
            cburst_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            rkind_reg  <= rkind_next;
            ncnt_reg   <= ncnt_next;
            scnt_reg   <= scnt_next;
            addr_reg   <= addr_next;
            left_reg   <= left_next;
            shift_reg  <= shift_next;
            bfail_reg  <= bfail_next;
            cburst_reg <= cburst_next;
        end
    end

    // next state and result for one bus clock
    always_comb
    begin
        phase_next  = phase_reg;
        rkind_next  = rkind_reg;
        ncnt_next   = ncnt_reg;
        scnt_next   = scnt_reg;
        addr_next   = addr_reg;
        left_next   = left_reg;
        shift_next  = shift_reg;
        bfail_next  = bfail_reg;
        cburst_next = cburst_reg;
        res         = '0;
        cycle_end   = 1'b0;
        cnt_byte    = 1'b0;
        full_addr   = '0;
        head_nib    = '0;
        ncnt_inc    = '0;

        // request pick-up on an idle clock
        go = (phase_reg == PH_IDLE) &&
             ((kind == KIND_LPC_READ) || (kind == KIND_LPC_WRITE) ||
              (kind == KIND_FWH_READ) || (kind == KIND_FWH_WRITE) ||
              ((kind == KIND_FWH_RUN) && (run_length != '0)));
        if (go)
        begin
            rkind_next  = kind;
            addr_next   = address[ADDRESS_BITS-1:0];
            shift_next  = write_data;
            left_next   = (kind == KIND_FWH_RUN) ? run_length : 25'd0;
            bfail_next  = 1'b0;
            scnt_next   = '0;
            cburst_next = pick_burst(kind, burst_en, 1'b0,
                                     address[ADDRESS_BITS-1:0],
                                     (kind == KIND_FWH_RUN) ? run_length : 25'd0);
            phase_next  = PH_HEAD;
            ncnt_next   = '0;
        end

        is_lpc = (rkind_next == KIND_LPC_READ) || (rkind_next == KIND_LPC_WRITE);
        is_wr  = (rkind_next == KIND_LPC_WRITE) || (rkind_next == KIND_FWH_WRITE);
        res.busy_res = (phase_next != PH_IDLE);
        ncnt_inc = ncnt_next + 1'b1;

        // address with the top bits filled from the register
        full_addr = {8{top_nib}};
        full_addr[ADDRESS_BITS-1:0] = addr_next;

        unique case (phase_next)
            PH_IDLE:
            begin
            end
            PH_HEAD:
            begin
                priority if (ncnt_next == NC_W'(0))
                    head_nib = is_lpc ? NIB_LPC_START : (is_wr ? NIB_FWH_WR : NIB_FWH_RD);
                else if (ncnt_next == NC_W'(1))
                    head_nib = is_lpc ? (is_wr ? NIB_LPC_WR : NIB_LPC_RD) : idsel;
                else if (is_lpc && ncnt_next <= NC_W'(9))
                    head_nib = full_addr[5'(4 * (9 - 32'(ncnt_next))) +: 4];
                else if (!is_lpc && ncnt_next <= NC_W'(8))
                    head_nib = full_addr[5'(4 * (8 - 32'(ncnt_next))) +: 4];
                else if (!is_lpc && ncnt_next == NC_W'(9))
                    head_nib = cburst_next ? SIZE_CODE : 4'd0;
                else if (ncnt_next == NC_W'(10))
                    head_nib = shift_next[3:0];
                else
                    head_nib = shift_next[7:4];
                res.lad_out      = head_nib;
                res.lad_drive    = 1'b1;
                res.frame_active = (ncnt_next == '0);
                ncnt_next        = ncnt_inc;
                if (ncnt_inc >= (is_wr ? NC_W'(12) : NC_W'(10)))
                begin
                    phase_next = PH_TAR_DRIVE;
                    ncnt_next  = '0;
                end
            end
            PH_TAR_DRIVE:
            begin
                res.lad_out   = NIB_ONES;
                res.lad_drive = 1'b1;
                phase_next    = PH_TAR_FREE;
            end
            PH_TAR_FREE:
            begin
                phase_next = PH_SYNC;
                scnt_next  = '0;
            end
            PH_SYNC:
            begin
                priority if (lad_in == 4'd0)
                begin
                    phase_next = is_wr ? PH_END : PH_DATA;
                    ncnt_next  = '0;
                end
                else if (scnt_next >= sync_limit)
                    phase_next = PH_ABORT;
                else
                    scnt_next = scnt_next + 8'd1;
            end
            PH_DATA:
            begin
                if (!ncnt_next[0])
                    shift_next = {4'd0, lad_in};
                else
                begin
                    shift_next     = {lad_in, shift_next[3:0]};
                    res.byte_valid = 1'b1;
                    res.read_byte  = {lad_in, shift_next[3:0]};
                    cnt_byte       = 1'b1;
                end
                ncnt_next = ncnt_inc;
                if (ncnt_inc >= (cburst_next ? BURST_NIBS : NC_W'(2)))
                begin
                    phase_next = PH_END;
                    ncnt_next  = '0;
                end
            end
            PH_END:
            begin
                if (ncnt_next == '0)
                    ncnt_next = NC_W'(1);
                else
                begin
                    ncnt_next = '0;
                    cycle_end = 1'b1;
                end
            end
            PH_ABORT:
            begin
                res.lad_out      = NIB_ONES;
                res.lad_drive    = 1'b1;
                res.frame_active = 1'b1;
                res.status       = 1'b1;
                if (cburst_next)
                    bfail_next = 1'b1;
                else if (!is_wr)
                begin
                    res.byte_valid = 1'b1;
                    res.read_byte  = 8'hFF;
                    cnt_byte       = 1'b1;
                end
                cycle_end = 1'b1;
            end
            default:
            begin
            end
        endcase

        // byte accounting for run reads
        if (cnt_byte && (rkind_next == KIND_FWH_RUN))
        begin
            if (left_next != '0)
                left_next = left_next - 25'd1;
            addr_next = addr_next + 1'b1;
        end

        // end of a bus cycle: next cycle of the run or request done
        if (cycle_end)
        begin
            if ((rkind_next == KIND_FWH_RUN) && (left_next != '0))
            begin
                phase_next  = PH_HEAD;
                ncnt_next   = '0;
                cburst_next = pick_burst(rkind_next, burst_en, bfail_next,
                                         addr_next, left_next);
            end
            else
            begin
                res.request_done = 1'b1;
                phase_next       = PH_IDLE;
                cburst_next      = 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.request_done |-> res.busy_res)
        else $error("done outside a request");
    a_abort_flags: assert property (@(posedge clk) disable iff (!rst_n)
        res.status |-> (res.frame_active && res.lad_drive))
        else $error("abort without frame");
    a_burst_size: assert property (@(posedge clk) disable iff (!rst_n)
        cburst_reg |-> (rkind_reg == KIND_FWH_RUN))
        else $error("burst on non-run request");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/lpc_fwh_host_cycle_engine.sv
// LPC/FWH host cycle engine: one input request per bus clock, one result each.
// Each accepted request's result is registered in the output buffer.
// Throughput: one request per cycle; in_stall rises only while two results wait.
// Reset: rst_n asynchronous, active low; engine idle, registers at reset values.
// Depends on lfh_pkg, lfh_engine and lfh_out_buf.
`timescale 1ns / 1ps
`default_nettype none
module lpc_fwh_host_cycle_engine
    import lfh_pkg::*;
#(
    parameter int BURST_BYTES  = 128,
    parameter int ADDRESS_BITS = 24
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  kind,
    input  wire logic [23:0] address,
    input  wire logic [7:0]  write_data,
    input  wire logic [24:0] run_length,
    input  wire logic [3:0]  lad_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       lad_out,
    output logic             lad_drive,
    output logic             frame_active,
    output logic             byte_valid,
    output logic [7:0]       read_byte,
    output logic             request_done,
    output logic             status,
    output logic             busy_res
);
    logic [7:0] sync_limit_reg;
    logic       burst_en_reg;
    logic [3:0] idsel_reg, top_nib_reg;
    logic       room, step;
    result_t    res, out_res;

    assign in_stall = !room;
    assign step     = in_valid && room;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_limit_reg <= 8'd32;
            burst_en_reg   <= 1'b0;
            idsel_reg      <= 4'd0;
            top_nib_reg    <= 4'hF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SYNC_LIMIT: sync_limit_reg <= cfg_data;
                REG_BURST_EN:   burst_en_reg   <= cfg_data[0];
                REG_IDSEL:      idsel_reg      <= cfg_data[3:0];
                REG_TOP_NIB:    top_nib_reg    <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    lfh_engine #(
        .BURST_BYTES  (BURST_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .kind       (kind),
        .address    (address),
        .write_data (write_data),
        .run_length (run_length),
        .lad_in     (lad_in),
        .sync_limit (sync_limit_reg),
        .burst_en   (burst_en_reg),
        .idsel      (idsel_reg),
        .top_nib    (top_nib_reg),
        .res        (res)
    );

    lfh_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_data (res),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_res)
    );

    assign lad_out      = out_res.lad_out;
    assign lad_drive    = out_res.lad_drive;
    assign frame_active = out_res.frame_active;
    assign byte_valid   = out_res.byte_valid;
    assign read_byte    = out_res.read_byte;
    assign request_done = out_res.request_done;
    assign status       = out_res.status;
    assign busy_res     = out_res.busy_res;

`ifndef SYNTH
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result waiting");
    a_cfg_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> (sync_limit_reg == 8'd32))
        else $error("timeout limit not at reset value");
    a_drive_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_active) |-> lad_drive)
        else $error("frame without driving LAD");
`endif
endmodule
`default_nettype wire

FILE: sim/lpc_fwh_host_cycle_engine_tb.sv
// Testbench for the LPC/FWH host cycle engine: drives bus-clock requests, predicts each
// result with a behavioural copy of the engine and checks every result field by field.
// Depends on lfh_pkg and the lpc_fwh_host_cycle_engine RTL.
`timescale 1ns / 1ps
module lpc_fwh_host_cycle_engine_tb;
    import lfh_pkg::*;

    localparam int BURST_BYTES = 128;
    localparam logic [3:0] MSIZE_BURST = 4'($clog2(BURST_BYTES));

    // how the bus side answers SYNC
    localparam int SYNC_NORMAL = 0;
    localparam int SYNC_NEVER  = 1;
    localparam int SYNC_NO_BURST = 2;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  kind = '0;
    logic [23:0] address = '0;
    logic [7:0]  write_data = '0;
    logic [24:0] run_length = '0;
    logic [3:0]  lad_in = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  lad_out;
    logic        lad_drive;
    logic        frame_active;
    logic        byte_valid;
    logic [7:0]  read_byte;
    logic        request_done;
    logic        status;
    logic        busy_res;

    lpc_fwh_host_cycle_engine dut (.*);

    always #5 clk = ~clk;

    // predicted engine state and registers
    logic [7:0]  m_sync_limit;
    logic        m_burst_en;
    logic [3:0]  m_idsel;
    logic [3:0]  m_top_nib;
    phase_t      m_phase;
    logic [2:0]  m_kind;
    int          m_nib;
    logic [7:0]  m_sync_cnt;
    logic [23:0] m_addr;
    logic [24:0] m_left;
    logic [7:0]  m_shift;
    logic        m_burst_failed;
    logic        m_burst;

    result_t bus_results_due[$];
    int      fail_count = 0;
    int      clocks_sent = 0;
    int      requests_sent = 0;
    int      bytes_seen = 0;
    int      aborts_seen = 0;
    int      sync_mode = SYNC_NORMAL;
    bit      calm = 1'b0;
    int      stall_left = 0;

    function automatic bit m_is_lpc();
        return m_kind == KIND_LPC_READ || m_kind == KIND_LPC_WRITE;
    endfunction

    function automatic bit m_is_write();
        return m_kind == KIND_LPC_WRITE || m_kind == KIND_FWH_WRITE;
    endfunction

    function automatic bit choose_burst();
        return m_kind == KIND_FWH_RUN && m_burst_en && !m_burst_failed &&
               (m_addr & 24'(BURST_BYTES - 1)) == 0 && m_left >= 25'(BURST_BYTES);
    endfunction

    function automatic logic [3:0] frame_nibble(int idx);
        logic [31:0] full;
        full = {{2{m_top_nib}}, m_addr};
        if (idx == 0)
            return m_is_lpc() ? NIB_LPC_START : (m_is_write() ? NIB_FWH_WR : NIB_FWH_RD);
        if (idx == 1)
            return m_is_lpc() ? (m_is_write() ? NIB_LPC_WR : NIB_LPC_RD) : m_idsel;
        if (m_is_lpc() && idx <= 9)
            return full[4 * (9 - idx) +: 4];
        if (!m_is_lpc() && idx <= 8)
            return full[4 * (8 - idx) +: 4];
        if (!m_is_lpc() && idx == 9)
            return m_burst ? MSIZE_BURST : 4'h0;
        return (idx == 10) ? m_shift[3:0] : m_shift[7:4];
    endfunction

    function automatic void take_byte();
        if (m_kind == KIND_FWH_RUN)
        begin
            if (m_left != 0)
                m_left--;
            m_addr++;
        end
    endfunction

    function automatic void engine_reset();
        m_sync_limit = 8'd32;
        m_burst_en = 1'b0;
        m_idsel = 4'h0;
        m_top_nib = 4'hF;
        m_phase = PH_IDLE;
        m_kind = KIND_TICK;
        m_nib = 0;
        m_sync_cnt = '0;
        m_addr = '0;
        m_left = '0;
        m_shift = '0;
        m_burst_failed = 1'b0;
        m_burst = 1'b0;
    endfunction

    // one bus clock of the engine
    function automatic result_t bus_clock(logic [2:0] k, logic [23:0] a, logic [7:0] wd,
                                          logic [24:0] rl, logic [3:0] lad);
        result_t r;
        bit      ends;
        r = '0;
        ends = 1'b0;
        if (m_phase == PH_IDLE &&
            ((k >= KIND_LPC_READ && k <= KIND_FWH_WRITE) || (k == KIND_FWH_RUN && rl != 0)))
        begin
            m_kind = k;
            m_addr = a;
            m_shift = wd;
            m_left = (k == KIND_FWH_RUN) ? rl : '0;
            m_burst_failed = 1'b0;
            m_sync_cnt = '0;
            m_burst = choose_burst();
            m_phase = PH_HEAD;
            m_nib = 0;
        end
        r.busy_res = (m_phase != PH_IDLE);
        case (m_phase)
            PH_HEAD:
            begin
                r.lad_out = frame_nibble(m_nib);
                r.lad_drive = 1'b1;
                r.frame_active = (m_nib == 0);
                m_nib++;
                if (m_nib >= (m_is_write() ? 12 : 10))
                begin
                    m_phase = PH_TAR_DRIVE;
                    m_nib = 0;
                end
            end
            PH_TAR_DRIVE:
            begin
                r.lad_out = NIB_ONES;
                r.lad_drive = 1'b1;
                m_phase = PH_TAR_FREE;
            end
            PH_TAR_FREE:
            begin
                m_phase = PH_SYNC;
                m_sync_cnt = '0;
            end
            PH_SYNC:
            begin
                if (lad == 4'h0)
                begin
                    m_phase = m_is_write() ? PH_END : PH_DATA;
                    m_nib = 0;
                end
                else if (m_sync_cnt >= m_sync_limit)
                    m_phase = PH_ABORT;
                else
                    m_sync_cnt++;
            end
            PH_DATA:
            begin
                if (m_nib[0] == 1'b0)
                    m_shift = {4'h0, lad};
                else
                begin
                    m_shift = {lad, m_shift[3:0]};
                    r.byte_valid = 1'b1;
                    r.read_byte = m_shift;
                    take_byte();
                end
                m_nib++;
                if (m_nib >= (m_burst ? 2 * BURST_BYTES : 2))
                begin
                    m_phase = PH_END;
                    m_nib = 0;
                end
            end
            PH_END:
            begin
                if (m_nib == 0)
                    m_nib = 1;
                else
                begin
                    m_nib = 0;
                    ends = 1'b1;
                end
            end
            PH_ABORT:
            begin
                r.lad_out = NIB_ONES;
                r.lad_drive = 1'b1;
                r.frame_active = 1'b1;
                r.status = 1'b1;
                if (m_burst)
                    m_burst_failed = 1'b1;
                else if (!m_is_write())
                begin
                    r.byte_valid = 1'b1;
                    r.read_byte = 8'hFF;
                    take_byte();
                end
                ends = 1'b1;
            end
            default:
                m_phase = PH_IDLE;
        endcase
        if (ends)
        begin
            if (m_kind == KIND_FWH_RUN && m_left != 0)
            begin
                m_phase = PH_HEAD;
                m_nib = 0;
                m_burst = choose_burst();
            end
            else
            begin
                r.request_done = 1'b1;
                m_phase = PH_IDLE;
                m_burst = 1'b0;
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(string field, int got, int want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
        fail_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (bus_results_due.size() == 0)
                note_mismatch("unexpected result", 1, 0);
            else
            begin
                want = bus_results_due.pop_front();
                if (lad_out != want.lad_out) note_mismatch("lad_out", lad_out, want.lad_out);
                if (lad_drive != want.lad_drive)
                    note_mismatch("lad_drive", lad_drive, want.lad_drive);
                if (frame_active != want.frame_active)
                    note_mismatch("frame_active", frame_active, want.frame_active);
                if (byte_valid != want.byte_valid)
                    note_mismatch("byte_valid", byte_valid, want.byte_valid);
                if (read_byte != want.read_byte)
                    note_mismatch("read_byte", read_byte, want.read_byte);
                if (request_done != want.request_done)
                    note_mismatch("request_done", request_done, want.request_done);
                if (status != want.status) note_mismatch("status", status, want.status);
                if (busy_res != want.busy_res)
                    note_mismatch("busy_res", busy_res, want.busy_res);
                bytes_seen += want.byte_valid;
                aborts_seen += want.status;
            end
        end
    end

    // receiver stalls: mostly short, a few long, none started while calm
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // send one bus clock as a request; called and left at a falling edge
    task automatic send_clock(logic [2:0] k, logic [23:0] a, logic [7:0] wd,
                              logic [24:0] rl, logic [3:0] lad);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind <= k;
        address <= a;
        write_data <= wd;
        run_length <= rl;
        lad_in <= lad;
        in_valid <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        bus_results_due.push_back(bus_clock(k, a, wd, rl, lad));
        clocks_sent++;
        @(negedge clk);
    endtask

    // nibble the device answers with in the predicted phase
    function automatic logic [3:0] device_nibble();
        bit refuse;
        if (m_phase != PH_SYNC)
            return 4'($urandom_range(0, 15));
        refuse = (sync_mode == SYNC_NEVER) || (sync_mode == SYNC_NO_BURST && m_burst) ||
                 (sync_mode == SYNC_NORMAL && $urandom_range(0, 2) == 0);
        return refuse ? 4'($urandom_range(1, 15)) : 4'h0;
    endfunction

    // one request, then bus clocks carrying ignored noise until it completes
    task automatic run_request(logic [2:0] k, logic [23:0] a, logic [7:0] wd, logic [24:0] rl);
        send_clock(k, a, wd, rl, device_nibble());
        requests_sent++;
        while (m_phase != PH_IDLE)
            send_clock(3'($urandom_range(0, 7)), 24'($urandom), 8'($urandom),
                       25'($urandom), device_nibble());
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (bus_results_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SYNC_LIMIT: m_sync_limit = value;
            REG_BURST_EN:   m_burst_en = value[0];
            REG_IDSEL:      m_idsel = value[3:0];
            default:        m_top_nib = value[3:0];
        endcase
    endtask

    task automatic set_all(logic [7:0] lim, logic ben, logic [3:0] ids, logic [3:0] top);
        wait_idle();
        write_reg(REG_SYNC_LIMIT, lim);
        write_reg(REG_BURST_EN, {7'd0, ben});
        write_reg(REG_IDSEL, {4'd0, ids});
        write_reg(REG_TOP_NIB, {4'd0, top});
    endtask

    // single cycles of each kind at the field extremes, plus ignored kinds
    task automatic test_single_cycles();
        calm = 1'b1;
        run_request(KIND_LPC_READ, 24'h000000, 8'h00, '0);
        run_request(KIND_LPC_WRITE, 24'hFFFFFF, 8'hFF, '0);
        calm = 1'b0;
        set_all(8'd4, 1'b0, 4'hF, 4'h0);
        run_request(KIND_FWH_READ, 24'hFFFFFF, 8'hA5, '0);
        run_request(KIND_FWH_WRITE, 24'h000000, 8'h5A, '0);
        send_clock(3'd6, 24'h123456, 8'h00, 25'h1FFFFFF, 4'h0);
        send_clock(3'd7, 24'hFFFFFF, 8'hFF, 25'h1, 4'hF);
        send_clock(KIND_FWH_RUN, 24'h000010, 8'h00, '0, 4'h0);
        send_clock(KIND_TICK, 24'hABCDEF, 8'h11, 25'h1000000, 4'h3);
    endtask

    // SYNC never arrives: read returns FF, write just aborts, both limit extremes
    task automatic test_sync_timeout();
        set_all(8'd0, 1'b0, 4'h3, 4'hF);
        sync_mode = SYNC_NEVER;
        run_request(KIND_LPC_READ, 24'h00ABCD, 8'h00, '0);
        run_request(KIND_FWH_WRITE, 24'h123456, 8'h77, '0);
        set_all(8'd255, 1'b0, 4'h3, 4'hF);
        run_request(KIND_FWH_READ, 24'h654321, 8'h00, '0);
        sync_mode = SYNC_NORMAL;
        run_request(KIND_FWH_READ, 24'h654322, 8'h00, '0);
    endtask

    // run reads: singles up to alignment, a burst, a tail, and a failed burst
    task automatic test_run_reads();
        set_all(8'd8, 1'b1, 4'h9, 4'h7);
        run_request(KIND_FWH_RUN, 24'hFFFFFE, 8'h00, 25'd3);
        run_request(KIND_FWH_RUN, 24'h00007E, 8'h00, 25'(BURST_BYTES + 5));
        sync_mode = SYNC_NO_BURST;
        set_all(8'd1, 1'b1, 4'h9, 4'h7);
        run_request(KIND_FWH_RUN, 24'h000100, 8'h00, 25'(BURST_BYTES + 2));
        sync_mode = SYNC_NORMAL;
    endtask

    function automatic logic [7:0] pick_extreme(logic [7:0] top_value);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return top_value;
            default: return 8'($urandom_range(0, top_value));
        endcase
    endfunction

    // random requests with random content, occasional reconfiguration and bus faults
    task automatic test_random_traffic();
        int n;
        int start_clocks;
        logic [2:0] k;
        logic [23:0] a;
        logic [24:0] rl;
        n = 0;
        start_clocks = clocks_sent;
        while (clocks_sent - start_clocks < 600)
        begin
            if (n % 25 == 0)
                set_all(($urandom_range(0, 3) == 0) ? pick_extreme(8'd255)
                                                    : 8'($urandom_range(0, 6)),
                        1'($urandom), 4'(pick_extreme(8'd15)), 4'(pick_extreme(8'd15)));
            calm = (n % 40) < 6;
            sync_mode = ($urandom_range(0, 19) == 0) ? SYNC_NEVER : SYNC_NORMAL;
            if ($urandom_range(0, 9) == 0)
                send_clock(($urandom_range(0, 1) == 0) ? 3'($urandom_range(6, 7)) : KIND_TICK,
                           24'($urandom), 8'($urandom), 25'($urandom), 4'($urandom));
            k = 3'($urandom_range(1, 5));
            a = 24'($urandom);
            rl = 25'($urandom_range(1, 6));
            if (k == KIND_FWH_RUN && $urandom_range(0, 9) == 0)
            begin
                a = {a[23:7], 7'd0} - 24'($urandom_range(0, 3));
                rl = 25'($urandom_range(BURST_BYTES, BURST_BYTES + 8));
            end
            run_request(k, a, 8'($urandom), rl);
            n++;
        end
        calm = 1'b0;
        sync_mode = SYNC_NORMAL;
    endtask

    initial
    begin
        engine_reset();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_single_cycles();
        test_sync_timeout();
        test_run_reads();
        test_random_traffic();
        wait_idle();
        repeat (20) @(negedge clk);
        $display("covered %0d bus clocks in %0d requests: %0d bytes read, %0d sync aborts",
                 clocks_sent, requests_sent, bytes_seen, aborts_seen);
        if (fail_count == 0 && bus_results_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // overall time limit
    initial
    begin
        #50ms;
        $display("timeout with %0d results outstanding", bus_results_due.size());
        $display("FAILURE");
        $finish;
    end

endmodule
